[rtl/assert_macros.svh]
// assertion macros used by the slew limiter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

[rtl/asl_pkg.sv]
// shared types, constants and functions of the asymmetric slew limiter
package asl_pkg;

   localparam int unsigned CHANNELS_DEFAULT = 8;
   localparam int unsigned CHAN_W = 3;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned RATE_W = 31;
   localparam logic [RATE_W-1:0] RATE_RESET = 31'd65536;

   localparam int unsigned CSR_INDEX_W = 8;
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RISE_RATE = 8'd0,
      REG_FALL_RATE = 8'd1
   } csr_reg_type;

   localparam int unsigned MS_PER_SECOND = 1000;
   localparam int unsigned REM_W = 10;
   localparam int unsigned REM1_W = REM_W + 1;
   localparam int unsigned PROD_W = TIME_W + RATE_W;
   localparam int unsigned SAT_W = PROD_W - VALUE_W;
   localparam logic [SAT_W-1:0] SAT_HIGH = SAT_W'(MS_PER_SECOND);
   localparam int unsigned DIV_W = 42;
   localparam int unsigned DIV_STAGES = 6;
   localparam int unsigned DIV_STEP_BITS = DIV_W / DIV_STAGES;
   localparam int unsigned NUM_STAGES = DIV_STAGES + 3;
   localparam int unsigned STEP_W = VALUE_W + 1;
   localparam logic [STEP_W-1:0] STEP_SAT = {1'b1, {VALUE_W{1'b0}}};
   localparam int unsigned SLOT_CALC_W = 9;

   typedef struct packed {
      logic [DIV_W-1:0] quo;
      logic [REM_W-1:0] rem;
   } div_type;

   typedef struct packed {
      logic                valid;
      logic [CHAN_W-1:0]   channel;
      logic [VALUE_W-1:0]  target;
      logic [STEP_W-1:0]   step_rise;
      logic [STEP_W-1:0]   step_fall;
   } f_item_type;

   // DIV_STEP_BITS restoring steps of long division by the milliseconds per second
   function automatic div_type div_steps(input div_type d);
      div_type res;
      logic [REM1_W-1:0] t;
      res = d;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         t = {res.rem, res.quo[DIV_W-1]};
         res.quo = {res.quo[DIV_W-2:0], 1'b0};
         if (t >= REM1_W'(MS_PER_SECOND)) begin
            res.rem = REM_W'(t - REM1_W'(MS_PER_SECOND));
            res.quo[0] = 1'b1;
         end else begin
            res.rem = t[REM_W-1:0];
         end
      end
      return res;
   endfunction

   // channel folded onto the number of stored channels
   function automatic logic [SLOT_CALC_W-1:0] slot_of(input logic [CHAN_W-1:0] ch,
                                                      input logic [SLOT_CALC_W-1:0] n);
      logic [SLOT_CALC_W-1:0] r;
      r = SLOT_CALC_W'(ch);
      for (int i = 0; i < (1 << CHAN_W); i++) begin
         if (r >= n) begin
            r = r - n;
         end
      end
      return r;
   endfunction

endpackage

[rtl/asl_state_mem.sv]
// per-channel state memory with registered read and reset-cleared valid bits
module asl_state_mem #(
   parameter int unsigned DEPTH = asl_pkg::CHANNELS_DEFAULT,
   parameter int unsigned WIDTH = asl_pkg::VALUE_W,
   parameter int unsigned AW    = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   import asl_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic             entry_valid_ff [DEPTH];
   logic [WIDTH-1:0] rd_word_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= entry_valid_ff[rd_addr];
         end
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

[rtl/asl_step_pipe.sv]
// elapsed time, rate multiply and pipelined divide into rise and fall steps
module asl_step_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [asl_pkg::CHAN_W-1:0]   in_channel,
   input  logic [asl_pkg::TIME_W-1:0]   in_timestamp,
   input  logic [asl_pkg::VALUE_W-1:0]  in_target,
   input  logic [asl_pkg::TIME_W-1:0]   prev_time,
   input  logic [asl_pkg::RATE_W-1:0]   rise_rate,
   input  logic [asl_pkg::RATE_W-1:0]   fall_rate,
   input  logic                         out_ready,
   output asl_pkg::f_item_type          out_item,
   output logic                         last_load,
   output logic [asl_pkg::CHAN_W-1:0]   last_load_channel
);
   import asl_pkg::*;

   localparam int unsigned S_MUL  = 1;
   localparam int unsigned S_PROD = 2;
   localparam int unsigned S_DIV0 = 3;
   localparam int unsigned LAST   = NUM_STAGES - 1;
   localparam int unsigned LAST_D = DIV_STAGES - 1;

   logic               v_ff    [NUM_STAGES];
   logic               rdy     [NUM_STAGES+1];
   logic [CHAN_W-1:0]  chan_ff [NUM_STAGES];
   logic [VALUE_W-1:0] tgt_ff  [NUM_STAGES];
   logic [TIME_W-1:0]  time_ff;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [PROD_W-1:0]  prod_rise_ff, prod_rise_in;
   logic [PROD_W-1:0]  prod_fall_ff, prod_fall_in;
   logic               sat_rise_in, sat_fall_in;
   div_type            seed_rise, seed_fall;
   div_type            div_rise_ff [DIV_STAGES];
   div_type            div_fall_ff [DIV_STAGES];
   div_type            div_rise_in [DIV_STAGES];
   div_type            div_fall_in [DIV_STAGES];
   logic               sat_rise_ff [DIV_STAGES];
   logic               sat_fall_ff [DIV_STAGES];

   always_comb begin
      rdy[NUM_STAGES] = out_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      elapsed_in = (time_ff >= prev_time) ? (time_ff - prev_time) : '0;
      prod_rise_in = PROD_W'(elapsed_ff) * PROD_W'(rise_rate);
      prod_fall_in = PROD_W'(elapsed_ff) * PROD_W'(fall_rate);
      sat_rise_in = prod_rise_ff[PROD_W-1:VALUE_W] >= SAT_HIGH;
      sat_fall_in = prod_fall_ff[PROD_W-1:VALUE_W] >= SAT_HIGH;
      seed_rise.quo = prod_rise_ff[DIV_W-1:0];
      seed_rise.rem = '0;
      seed_fall.quo = prod_fall_ff[DIV_W-1:0];
      seed_fall.rem = '0;
      div_rise_in[0] = div_steps(seed_rise);
      div_fall_in[0] = div_steps(seed_fall);
      for (int d = 1; d < DIV_STAGES; d++) begin
         div_rise_in[d] = div_steps(div_rise_ff[d-1]);
         div_fall_in[d] = div_steps(div_fall_ff[d-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         chan_ff[0] <= in_channel;
         tgt_ff[0]  <= in_target;
         time_ff    <= in_timestamp;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (rdy[k]) begin
            chan_ff[k] <= chan_ff[k-1];
            tgt_ff[k]  <= tgt_ff[k-1];
         end
      end
      if (rdy[S_MUL]) begin
         elapsed_ff <= elapsed_in;
      end
      if (rdy[S_PROD]) begin
         prod_rise_ff <= prod_rise_in;
         prod_fall_ff <= prod_fall_in;
      end
      if (rdy[S_DIV0]) begin
         sat_rise_ff[0] <= sat_rise_in;
         sat_fall_ff[0] <= sat_fall_in;
      end
      for (int d = 0; d < DIV_STAGES; d++) begin
         if (rdy[S_DIV0+d]) begin
            div_rise_ff[d] <= div_rise_in[d];
            div_fall_ff[d] <= div_fall_in[d];
         end
      end
      for (int d = 1; d < DIV_STAGES; d++) begin
         if (rdy[S_DIV0+d]) begin
            sat_rise_ff[d] <= sat_rise_ff[d-1];
            sat_fall_ff[d] <= sat_fall_ff[d-1];
         end
      end
   end

   always_comb begin
      out_item.valid     = v_ff[LAST];
      out_item.channel   = chan_ff[LAST];
      out_item.target    = tgt_ff[LAST];
      out_item.step_rise = sat_rise_ff[LAST_D] ? STEP_SAT
                                               : {1'b0, div_rise_ff[LAST_D].quo[VALUE_W-1:0]};
      out_item.step_fall = sat_fall_ff[LAST_D] ? STEP_SAT
                                               : {1'b0, div_fall_ff[LAST_D].quo[VALUE_W-1:0]};
   end

   assign last_load         = rdy[LAST] && v_ff[LAST-1];
   assign last_load_channel = chan_ff[LAST-1];

endmodule

[rtl/asl_update.sv]
// held output read-modify-write with bypass and the result register
module asl_update #(
   parameter int unsigned CHANNELS = asl_pkg::CHANNELS_DEFAULT,
   parameter int unsigned SLOT_W   = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  asl_pkg::f_item_type               in_item,
   output logic                              in_ready,
   input  logic [asl_pkg::VALUE_W-1:0]       held_rdata,
   output logic                              held_we,
   output logic [SLOT_W-1:0]                 held_waddr,
   output logic [asl_pkg::VALUE_W-1:0]       held_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [asl_pkg::CHAN_W-1:0]        rsp_out_channel,
   output logic signed [asl_pkg::VALUE_W-1:0] rsp_output_value,
   output logic                              rsp_changed
);
   import asl_pkg::*;

   logic [SLOT_CALC_W-1:0] slot_full;
   logic [SLOT_W-1:0]      slot;
   logic [VALUE_W-1:0]     cur, target, moved, next_value;
   logic [STEP_W-1:0]      dist_up, dist_dn, distance, step;
   logic                   rising, same, clamp, changed_in, fire;

   logic                   rsp_valid_ff;
   logic [CHAN_W-1:0]      chan_ff;
   logic [VALUE_W-1:0]     value_ff;
   logic                   changed_ff;
   logic                   fwd_valid_ff;
   logic [SLOT_W-1:0]      fwd_slot_ff;
   logic [VALUE_W-1:0]     fwd_value_ff;

   always_comb begin
      slot_full = slot_of(in_item.channel, SLOT_CALC_W'(CHANNELS));
      slot      = slot_full[SLOT_W-1:0];
      target    = in_item.target;
      cur       = (fwd_valid_ff && (fwd_slot_ff == slot)) ? fwd_value_ff : held_rdata;
      rising    = $signed(target) > $signed(cur);
      same      = target == cur;
      dist_up   = {target[VALUE_W-1], target} - {cur[VALUE_W-1], cur};
      dist_dn   = {cur[VALUE_W-1], cur} - {target[VALUE_W-1], target};
      distance  = rising ? dist_up : dist_dn;
      step      = rising ? in_item.step_rise : in_item.step_fall;
      clamp     = step >= distance;
      moved     = rising ? (cur + step[VALUE_W-1:0]) : (cur - step[VALUE_W-1:0]);
      priority if (same) begin
         next_value = cur;
      end else if (clamp) begin
         next_value = target;
      end else begin
         next_value = moved;
      end
      changed_in = !same && (clamp || (step != '0));
   end

   assign in_ready   = !rsp_valid_ff || rsp_ready;
   assign fire       = in_item.valid && in_ready;
   assign held_we    = fire;
   assign held_waddr = slot;
   assign held_wdata = next_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            rsp_valid_ff <= in_item.valid;
         end
         if (fire) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         chan_ff      <= in_item.channel;
         value_ff     <= next_value;
         changed_ff   <= changed_in;
         fwd_slot_ff  <= slot;
         fwd_value_ff <= next_value;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = chan_ff;
   assign rsp_output_value = value_ff;
   assign rsp_changed      = changed_ff;

endmodule

[rtl/asymmetric_slew_limiter_core.sv]
// a result passes the step pipeline and the result register, then waits for rsp_ready
// one item per cycle unless rsp_ready stalls, set by the held output update with bypass
// timestamps are read and rewritten together at accept, the step pipeline is 9 stages
// reset is synchronous: rates go to 65536 per second, per-channel valid bits clear at once
// an entry that was never written reads as zero, there is no clearing pass
`include "assert_macros.svh"

module asymmetric_slew_limiter_core #(
   parameter int unsigned CHANNELS = asl_pkg::CHANNELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [asl_pkg::CHAN_W-1:0]          req_channel,
   input  logic [asl_pkg::TIME_W-1:0]          req_timestamp_ms,
   input  logic signed [asl_pkg::VALUE_W-1:0]  req_target_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [asl_pkg::CHAN_W-1:0]          rsp_out_channel,
   output logic signed [asl_pkg::VALUE_W-1:0]  rsp_output_value,
   output logic                                rsp_changed,
   input  logic                                csr_we,
   input  logic [asl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [asl_pkg::RATE_W-1:0]          csr_wdata
);
   import asl_pkg::*;

   localparam int unsigned SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [RATE_W-1:0]      rise_rate_ff, fall_rate_ff;
   logic                   req_accept;
   logic [SLOT_CALC_W-1:0] req_slot_full, hrd_slot_full;
   logic [SLOT_W-1:0]      req_slot, hrd_slot;
   logic [TIME_W-1:0]      prev_time;
   f_item_type             f_item;
   logic                   f_ready;
   logic                   last_load;
   logic [CHAN_W-1:0]      last_load_channel;
   logic [VALUE_W-1:0]     held_rdata;
   logic                   held_we;
   logic [SLOT_W-1:0]      held_waddr;
   logic [VALUE_W-1:0]     held_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_rate_ff <= RATE_RESET;
         fall_rate_ff <= RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RISE_RATE: rise_rate_ff <= csr_wdata;
            REG_FALL_RATE: fall_rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      req_slot_full = slot_of(req_channel, SLOT_CALC_W'(CHANNELS));
      req_slot      = req_slot_full[SLOT_W-1:0];
      hrd_slot_full = slot_of(last_load_channel, SLOT_CALC_W'(CHANNELS));
      hrd_slot      = hrd_slot_full[SLOT_W-1:0];
   end

   assign req_accept = req_valid && req_ready;

   asl_state_mem #(
      .DEPTH (CHANNELS),
      .WIDTH (TIME_W),
      .AW    (SLOT_W)
   ) u_time_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept),
      .wr_addr (req_slot),
      .wr_data (req_timestamp_ms),
      .rd_en   (req_accept),
      .rd_addr (req_slot),
      .rd_data (prev_time)
   );

   asl_step_pipe u_step_pipe (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_valid),
      .in_ready          (req_ready),
      .in_channel        (req_channel),
      .in_timestamp      (req_timestamp_ms),
      .in_target         (req_target_value),
      .prev_time         (prev_time),
      .rise_rate         (rise_rate_ff),
      .fall_rate         (fall_rate_ff),
      .out_ready         (f_ready),
      .out_item          (f_item),
      .last_load         (last_load),
      .last_load_channel (last_load_channel)
   );

   asl_state_mem #(
      .DEPTH (CHANNELS),
      .WIDTH (VALUE_W),
      .AW    (SLOT_W)
   ) u_held_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (held_we),
      .wr_addr (held_waddr),
      .wr_data (held_wdata),
      .rd_en   (last_load),
      .rd_addr (hrd_slot),
      .rd_data (held_rdata)
   );

   asl_update #(
      .CHANNELS (CHANNELS),
      .SLOT_W   (SLOT_W)
   ) u_update (
      .clock            (clock),
      .reset            (reset),
      .in_item          (f_item),
      .in_ready         (f_ready),
      .held_rdata       (held_rdata),
      .held_we          (held_we),
      .held_waddr       (held_waddr),
      .held_wdata       (held_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_output_value (rsp_output_value),
      .rsp_changed      (rsp_changed)
   );

   `ASSERT_NEXT(held_write_reported, held_we, rsp_valid && (rsp_output_value == $past(held_wdata)), "result differs from written held output")
   `ASSERT_NEXT(update_stall_holds, f_item.valid && !f_ready, f_item.valid && $stable(f_item.target) && $stable(f_item.step_rise) && $stable(f_item.step_fall), "stalled item changed")
   `ASSERT_NOW(step_in_range, f_item.valid, (f_item.step_rise <= STEP_SAT) && (f_item.step_fall <= STEP_SAT), "step beyond saturation")

endmodule

[dv/asymmetric_slew_limiter_core_test.sv]
// self-checking testbench for the asymmetric slew limiter core with a predicting scoreboard
module asymmetric_slew_limiter_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import asl_pkg::*;

   localparam int unsigned NUM_CH = CHANNELS_DEFAULT;
   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned PHASE_ITEMS = 250;
   localparam int unsigned PHASES = 6;
   localparam logic [RATE_W-1:0] RATE_MAX = '1;

   typedef struct {
      logic [CHAN_W-1:0]         channel;
      logic signed [VALUE_W-1:0] value;
      logic                      changed;
   } slew_out_type;

   class slew_tracker;
      logic [RATE_W-1:0]         rise_rate;
      logic [RATE_W-1:0]         fall_rate;
      logic signed [VALUE_W-1:0] held[NUM_CH];
      logic [TIME_W-1:0]         last_time[NUM_CH];
      slew_out_type              predicted_outputs[$];
      int                        mismatches;

      function new();
         rise_rate = RATE_RESET;
         fall_rate = RATE_RESET;
         mismatches = 0;
         foreach (held[i]) begin
            held[i] = '0;
            last_time[i] = '0;
         end
      endfunction

      function void write_rate(logic [CSR_INDEX_W-1:0] idx, logic [RATE_W-1:0] value);
         if (idx == REG_RISE_RATE) begin
            rise_rate = value;
         end else if (idx == REG_FALL_RATE) begin
            fall_rate = value;
         end
      endfunction

      function void predict_item(logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] ts,
                                 logic signed [VALUE_W-1:0] tgt);
         slew_out_type              out;
         int                        slot;
         logic signed [VALUE_W-1:0] cur;
         logic signed [VALUE_W-1:0] nxt;
         logic [TIME_W-1:0]         elapsed;
         logic [63:0]               step;
         logic [63:0]               distance;
         logic signed [63:0]        diff;
         logic                      rising;
         slot = int'(ch) % NUM_CH;
         cur = held[slot];
         nxt = cur;
         elapsed = (ts >= last_time[slot]) ? ts - last_time[slot] : '0;
         if (tgt != cur) begin
            rising = tgt > cur;
            step = 64'(elapsed) * 64'(rising ? rise_rate : fall_rate);
            step = step / 64'(MS_PER_SECOND);
            diff = longint'(tgt) - longint'(cur);
            distance = rising ? diff : -diff;
            if (step >= distance) begin
               nxt = tgt;
            end else if (rising) begin
               nxt = cur + step[VALUE_W-1:0];
            end else begin
               nxt = cur - step[VALUE_W-1:0];
            end
         end
         held[slot] = nxt;
         last_time[slot] = ts;
         out.channel = ch;
         out.value = nxt;
         out.changed = (nxt != cur);
         predicted_outputs.push_back(out);
      endfunction

      function void compare_output(logic [CHAN_W-1:0] ch, logic signed [VALUE_W-1:0] val,
                                   logic chg);
         slew_out_type want;
         if (predicted_outputs.size() == 0) begin
            $error("unexpected result: out_channel %0d output_value %0d changed %0d",
                   ch, val, chg);
            mismatches++;
         end else begin
            want = predicted_outputs.pop_front();
            if (ch !== want.channel) begin
               $error("out_channel: expected %0d, actual %0d", want.channel, ch);
               mismatches++;
            end
            if (val !== want.value) begin
               $error("output_value: expected %0d, actual %0d", want.value, val);
               mismatches++;
            end
            if (chg !== want.changed) begin
               $error("changed: expected %0d, actual %0d", want.changed, chg);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [CHAN_W-1:0]           req_channel = '0;
   logic [TIME_W-1:0]           req_timestamp_ms = '0;
   logic signed [VALUE_W-1:0]   req_target_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [CHAN_W-1:0]           rsp_out_channel;
   logic signed [VALUE_W-1:0]   rsp_output_value;
   logic                        rsp_changed;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [RATE_W-1:0]           csr_wdata = '0;

   slew_tracker tracker = new();
   bit          send_steady = 1'b0;
   bit          recv_steady = 1'b0;
   bit          hold_off_request = 1'b0;
   int unsigned idle_cycles = 0;

   asymmetric_slew_limiter_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_channel      (req_channel),
      .req_timestamp_ms (req_timestamp_ms),
      .req_target_value (req_target_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_output_value (rsp_output_value),
      .rsp_changed      (rsp_changed),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_item(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] ts,
                            input logic signed [VALUE_W-1:0] tgt);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= ch;
      req_timestamp_ms <= ts;
      req_target_value <= tgt;
      do @(posedge clock); while (!req_ready);
      tracker.predict_item(ch, ts, tgt);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [RATE_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_rate(idx, value);
      @(posedge clock);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (tracker.predicted_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end
         gap = recv_steady ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.compare_output(rsp_out_channel, rsp_output_value, rsp_changed);
      end
   end

   initial begin
      logic [CSR_INDEX_W-1:0]    bad_index;
      logic [CHAN_W-1:0]         ch;
      logic [TIME_W-1:0]         ts;
      logic signed [VALUE_W-1:0] tgt;
      int                        slot;
      int                        kind;
      int                        delta;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_RISE_RATE, RATE_RESET);
      write_reg(REG_FALL_RATE, RATE_RESET);
      send_item(0, 0, 0);
      send_item(0, 1000, 32'sh7FFF_FFFF);
      send_item(0, 500, 32'sh7FFF_FFFF);
      send_item(0, 2000, 32'sh7FFF_FFFF);
      send_item(1, 32'hFFFF_FFFF, 32'sh8000_0000);
      send_item(1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
      send_item(1, 0, 32'sh7FFF_FFFF);
      send_item(2, 100, 32'sd1000);
      send_item(2, 200, -32'sd1000);
      send_item(2, 201, -32'sd1000);
      for (int c = 3; c < NUM_CH; c++) begin
         send_item(CHAN_W'(c), TIME_W'(50 * c), VALUE_W'(-(c * 4096)));
      end

      // zero rise rate, fastest fall
      quiesce();
      write_reg(REG_RISE_RATE, '0);
      write_reg(REG_FALL_RATE, RATE_MAX);
      send_item(3, 10000, 32'sh7FFF_FFFF);
      send_item(3, 10001, 32'sh8000_0000);
      send_item(3, 20000, 32'sh8000_0000);

      // fastest rise, zero fall rate
      quiesce();
      write_reg(REG_RISE_RATE, RATE_MAX);
      write_reg(REG_FALL_RATE, '0);
      send_item(4, 60000, 32'sh8000_0000);
      send_item(4, 61000, 32'sh7FFF_FFFF);

      // writes past the register list leave the rates alone
      quiesce();
      bad_index = CSR_INDEX_W'(REG_FALL_RATE + 1 + $urandom_range(0, 253));
      write_reg(bad_index, RATE_MAX);
      write_reg(CSR_INDEX_W'(REG_FALL_RATE + 1), '0);
      send_item(5, 70000, 32'sh7FFF_FFFF);
      send_item(5, 70001, 32'sh8000_0000);

      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         case (phase)
            0: begin
               write_reg(REG_RISE_RATE, RATE_RESET);
               write_reg(REG_FALL_RATE, RATE_RESET);
            end
            2: begin
               write_reg(REG_RISE_RATE, RATE_W'($urandom_range(0, 1 << 22)));
               write_reg(REG_FALL_RATE, RATE_W'($urandom_range(0, 1 << 22)));
            end
            3: begin
               write_reg(REG_RISE_RATE, RATE_MAX);
               write_reg(REG_FALL_RATE, RATE_W'($urandom_range(0, 1 << 16)));
            end
            4: begin
               write_reg(REG_RISE_RATE, '0);
               write_reg(REG_FALL_RATE, RATE_W'($urandom));
            end
            default: begin
               write_reg(REG_RISE_RATE, RATE_W'($urandom));
               write_reg(REG_FALL_RATE, RATE_W'($urandom));
            end
         endcase
         send_steady = ($urandom_range(0, 3) == 0);
         recv_steady = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            // stall the result side long enough to back up the input
            send_steady = 1'b1;
            hold_off_request = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            ch = CHAN_W'($urandom_range(0, 7));
            slot = int'(ch) % NUM_CH;
            kind = $urandom_range(0, 99);
            ts = tracker.last_time[slot] + $urandom_range(0, 200);
            delta = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            tgt = tracker.held[slot] + delta;
            if (kind < 60) begin
            end else if (kind < 70) begin
               tgt = tracker.held[slot];
            end else if (kind < 80) begin
               ts = tracker.last_time[slot] - $urandom_range(1, 1000);
            end else if (kind < 90) begin
               ts = $urandom;
               tgt = $urandom;
            end else begin
               ts = tracker.last_time[slot] + $urandom_range(0, 100000);
               tgt = $urandom;
            end
            send_item(ch, ts, tgt);
         end
      end

      quiesce();
      if (tracker.mismatches == 0 && tracker.predicted_outputs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
